[rtl/gha_pkg.sv]
// Package for the generational handle allocator.
// Holds sizes, op and status codes and the request kinds used by the top level.
// No dependencies.
`default_nettype none

package gha_pkg;

    localparam int SLOTS = 1024;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int VER_W = 32;

    typedef logic [1:0]       t_op;
    typedef logic [1:0]       t_status;
    typedef logic [2:0]       t_kind;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [VER_W-1:0] t_ver;

    localparam t_op OP_ALLOC   = 2'd0;
    localparam t_op OP_RELEASE = 2'd1;
    localparam t_op OP_CHECK   = 2'd2;

    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_NO_SLOT    = 2'd1;
    localparam t_status ST_NOT_ISSUED = 2'd2;
    localparam t_status ST_STACK_FULL = 2'd3;

    // what a request turned out to be once decoded against the counters
    localparam t_kind K_NONE    = 3'd0;
    localparam t_kind K_POP     = 3'd1;
    localparam t_kind K_FRESH   = 3'd2;
    localparam t_kind K_REL     = 3'd3;
    localparam t_kind K_CHK     = 3'd4;
    localparam t_kind K_NOSLOT  = 3'd5;
    localparam t_kind K_NOTISS  = 3'd6;
    localparam t_kind K_FULL    = 3'd7;

endpackage

`default_nettype wire

[rtl/gha_ram.sv]
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered and held while the read enable is low. No dependencies.
`default_nettype none

module gha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/generational_handle_allocator.sv]
// Top level of the generational handle allocator.
// Uses gha_pkg and two gha_ram instances (slot versions, free stack).
//
//   port group   dir  handshake            payload
//   request      in   i_valid / o_stall    i_op, i_handle_index, i_handle_version
//   result       out  o_valid / i_stall    o_new_index, o_new_version,
//                                          o_is_valid, o_status
//
// One word in and one word out per cycle while i_stall does not hold the output; from accept
// a word passes stage 1 (stack read), stage 2 (version read) and the output register to o_valid.
// Counters update at accept; versions are written in the last stage, with a
// one-entry bypass covering the read that overlaps the preceding write.
// Synchronous active-low reset clears counters and stage valids; RAMs need no clearing.
// i_stall holds the output; bubbles still close up, o_stall rises when stage 1 cannot move.
`default_nettype none

module generational_handle_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [9:0]  i_handle_index,
    input  wire logic [31:0] i_handle_version,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [9:0]       o_new_index,
    output logic [31:0]      o_new_version,
    output logic             o_is_valid,
    output logic [1:0]       o_status
);

    gha_pkg::t_cnt r_free_cnt, n_free_cnt;
    gha_pkg::t_cnt r_issued, n_issued;

    logic              r_s1_vld;
    gha_pkg::t_kind    r_s1_kind;
    gha_pkg::t_idx     r_s1_idx;
    gha_pkg::t_ver     r_s1_ver;

    logic              r_s2_vld;
    gha_pkg::t_kind    r_s2_kind;
    gha_pkg::t_idx     r_s2_idx;
    gha_pkg::t_ver     r_s2_ver;

    logic              r_out_vld;
    gha_pkg::t_idx     r_out_idx;
    gha_pkg::t_ver     r_out_ver;
    logic              r_out_ok;
    gha_pkg::t_status  r_out_st;

    logic              r_wb_vld;
    gha_pkg::t_idx     r_wb_addr;
    gha_pkg::t_ver     r_wb_data;

    logic              out_free, s2_mv, s2_free, s1_mv, s1_free, accept;
    gha_pkg::t_kind    n_kind;
    gha_pkg::t_idx     n_idx;
    gha_pkg::t_idx     stk_rdata;
    gha_pkg::t_idx     ver_raddr;
    gha_pkg::t_ver     ver_rdata;
    gha_pkg::t_ver     ver_cur;
    logic              ver_we;
    gha_pkg::t_ver     ver_wdata;
    logic              idx_issued;

    gha_pkg::t_idx     n_out_idx;
    gha_pkg::t_ver     n_out_ver;
    logic              n_out_ok;
    gha_pkg::t_status  n_out_st;

    // pipe advance
    assign out_free = !r_out_vld || !i_stall;
    assign s2_mv    = r_s2_vld && out_free;
    assign s2_free  = !r_s2_vld || s2_mv;
    assign s1_mv    = r_s1_vld && s2_free;
    assign s1_free  = !r_s1_vld || s1_mv;
    assign o_stall  = !s1_free;
    assign accept   = i_valid && s1_free;

    // decode against the counters at accept
    assign idx_issued = {1'b0, i_handle_index} < r_issued;

    always_comb begin
        n_kind     = gha_pkg::K_NONE;
        n_idx      = i_handle_index;
        n_free_cnt = r_free_cnt;
        n_issued   = r_issued;
        case (i_op)
            gha_pkg::OP_ALLOC: begin
                if (r_free_cnt != '0) begin
                    n_kind     = gha_pkg::K_POP;
                    n_free_cnt = r_free_cnt - 1'b1;
                end else if (r_issued < gha_pkg::CNT_W'(gha_pkg::SLOTS)) begin
                    n_kind   = gha_pkg::K_FRESH;
                    n_idx    = r_issued[gha_pkg::IDX_W-1:0];
                    n_issued = r_issued + 1'b1;
                end else begin
                    n_kind = gha_pkg::K_NOSLOT;
                end
            end
            gha_pkg::OP_RELEASE: begin
                if (!idx_issued) begin
                    n_kind = gha_pkg::K_NOTISS;
                end else if (r_free_cnt >= gha_pkg::CNT_W'(gha_pkg::SLOTS)) begin
                    n_kind = gha_pkg::K_FULL;
                end else begin
                    n_kind     = gha_pkg::K_REL;
                    n_free_cnt = r_free_cnt + 1'b1;
                end
            end
            gha_pkg::OP_CHECK: begin
                n_kind = idx_issued ? gha_pkg::K_CHK : gha_pkg::K_NOTISS;
            end
            default: begin
                n_kind = gha_pkg::K_NONE;
            end
        endcase
    end

    // free stack: push writes at accept, pop reads the top at accept
    gha_ram #(
        .WIDTH(gha_pkg::IDX_W),
        .DEPTH(gha_pkg::SLOTS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (accept && (n_kind == gha_pkg::K_REL)),
        .i_waddr (r_free_cnt[gha_pkg::IDX_W-1:0]),
        .i_wdata (i_handle_index),
        .i_re    (accept && (n_kind == gha_pkg::K_POP)),
        .i_raddr (n_free_cnt[gha_pkg::IDX_W-1:0]),
        .o_rdata (stk_rdata)
    );

    // slot versions: read as the word enters stage 2, written as it leaves
    assign ver_raddr = (r_s1_kind == gha_pkg::K_POP) ? stk_rdata : r_s1_idx;

    gha_ram #(
        .WIDTH(gha_pkg::VER_W),
        .DEPTH(gha_pkg::SLOTS)
    ) u_ver (
        .i_clk   (i_clk),
        .i_we    (ver_we),
        .i_waddr (r_s2_idx),
        .i_wdata (ver_wdata),
        .i_re    (s1_mv),
        .i_raddr (ver_raddr),
        .o_rdata (ver_rdata)
    );

    // bypass the write that landed on the same edge as this word's read
    assign ver_cur = (r_wb_vld && (r_wb_addr == r_s2_idx)) ? r_wb_data : ver_rdata;

    always_comb begin
        n_out_idx = '0;
        n_out_ver = '0;
        n_out_ok  = 1'b0;
        n_out_st  = gha_pkg::ST_OK;
        ver_we    = 1'b0;
        ver_wdata = ver_cur + 1'b1;
        case (r_s2_kind)
            gha_pkg::K_POP: begin
                n_out_idx = r_s2_idx;
                n_out_ver = ver_cur;
            end
            gha_pkg::K_FRESH: begin
                n_out_idx = r_s2_idx;
                n_out_ver = gha_pkg::VER_W'(1);
                ver_we    = s2_mv;
                ver_wdata = gha_pkg::VER_W'(1);
            end
            gha_pkg::K_REL: begin
                ver_we = s2_mv;
            end
            gha_pkg::K_CHK: begin
                n_out_ok = (ver_cur == r_s2_ver);
            end
            gha_pkg::K_NOSLOT: begin
                n_out_st = gha_pkg::ST_NO_SLOT;
            end
            gha_pkg::K_NOTISS: begin
                n_out_st = gha_pkg::ST_NOT_ISSUED;
            end
            gha_pkg::K_FULL: begin
                n_out_st = gha_pkg::ST_STACK_FULL;
            end
            default: begin
                n_out_st = gha_pkg::ST_OK;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_cnt <= '0;
            r_issued   <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_wb_vld   <= 1'b0;
        end else begin
            if (accept) begin
                r_free_cnt <= n_free_cnt;
                r_issued   <= n_issued;
            end
            if (s1_free) begin
                r_s1_vld <= i_valid;
            end
            if (s2_free) begin
                r_s2_vld <= r_s1_vld;
            end
            if (out_free) begin
                r_out_vld <= r_s2_vld;
            end
            if (ver_we) begin
                r_wb_vld <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind <= n_kind;
            r_s1_idx  <= n_idx;
            r_s1_ver  <= i_handle_version;
        end
        if (s1_mv) begin
            r_s2_kind <= r_s1_kind;
            r_s2_idx  <= ver_raddr;
            r_s2_ver  <= r_s1_ver;
        end
        if (s2_mv) begin
            r_out_idx <= n_out_idx;
            r_out_ver <= n_out_ver;
            r_out_ok  <= n_out_ok;
            r_out_st  <= n_out_st;
        end
        if (ver_we) begin
            r_wb_addr <= r_s2_idx;
            r_wb_data <= ver_wdata;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_new_index   = r_out_idx;
    assign o_new_version = r_out_ver;
    assign o_is_valid    = r_out_ok;
    assign o_status      = r_out_st;

endmodule

`default_nettype wire
